[rtl/m4inv_pkg.sv]
package m4inv_pkg;

  // Field and datapath widths
  localparam int ELEM_W  = 32;   // Q16.16 element
  localparam int THR_W   = 31;   // threshold register
  localparam int D_W     = 66;   // 2x2 minor, 32 fraction bits
  localparam int C_W     = 99;   // 3x3 minor / cofactor, 48 fraction bits
  localparam int OPA_W   = 100;  // wide multiplier operand, sign extended
  localparam int OPND_W  = 36;   // one limb slice fed to the multiplier
  localparam int PROD_W  = 68;   // limb x element product
  localparam int ACC_W   = 133;  // determinant, 64 fraction bits
  localparam int DET_FRAC = 48;  // fraction bits dropped for the Q16.16 determinant
  localparam int HI_W    = ACC_W - DET_FRAC;

  localparam logic [THR_W-1:0] THR_RESET = 31'd66;
  localparam logic [4:0] MINOR_LAST = 5'd18;
  localparam logic [4:0] DET_LAST   = 5'd7;
  localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

  // Load item
  typedef struct packed {
    logic signed [ELEM_W-1:0] element_value;
    logic [1:0]               row_index;
    logic [1:0]               col_index;
    logic                     last_element;
  } m4inv_in_t;

  // Result item
  typedef struct packed {
    logic signed [ELEM_W-1:0] inverse_value;
    logic [1:0]               out_row;
    logic [1:0]               out_col;
    logic signed [ELEM_W-1:0] determinant_value;
    logic                     singular_flag;
    logic                     last_result;
  } m4inv_out_t;

  // Sequencer micro-operations
  typedef enum logic [2:0] {
    OP_LDA  = 3'd0,  // operand A <= matrix element
    OP_LDC  = 3'd1,  // operand A <= cofactor
    OP_MAC  = 3'd2,  // accumulator +/-= operand A * matrix element
    OP_MOVD = 3'd3,  // operand A <= 2x2 minor, clear it
    OP_STC  = 3'd4   // store cofactor, clear accumulator
  } uop_kind_t;

  typedef struct packed {
    uop_kind_t  kind;
    logic [1:0] rsel;    // row among the three kept rows
    logic [1:0] csel;    // column among the three kept columns
    logic       neg;     // subtract the product
    logic       to_m;    // target: wide accumulator (else 2x2 accumulator)
    logic [1:0] nlimbs;  // limbs of operand A
  } uop_t;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_OP     = 12'b0000_0000_0010,
    S_LAT    = 12'b0000_0000_0100,
    S_MUL    = 12'b0000_0000_1000,
    S_ACC    = 12'b0000_0001_0000,
    S_DMAG   = 12'b0000_0010_0000,
    S_DCHK   = 12'b0000_0100_0000,
    S_CFETCH = 12'b0000_1000_0000,
    S_CLOAD  = 12'b0001_0000_0000,
    S_CCMP   = 12'b0010_0000_0000,
    S_DSTEP  = 12'b0100_0000_0000,
    S_FIN    = 12'b1000_0000_0000
  } state_t;

  function automatic uop_t mk_uop(uop_kind_t kind, logic [1:0] rsel, logic [1:0] csel,
                                  logic neg, logic to_m, logic [1:0] nlimbs);
    uop_t u;
    u.kind   = kind;
    u.rsel   = rsel;
    u.csel   = csel;
    u.neg    = neg;
    u.to_m   = to_m;
    u.nlimbs = nlimbs;
    return u;
  endfunction

  // 3x3 minor program: three 2x2 minors of the lower kept rows, each
  // weighted by an element of the first kept row.
  function automatic uop_t minor_uop(logic [4:0] step);
    uop_t u;
    case (step)
      5'd0:    u = mk_uop(OP_LDA,  2'd1, 2'd1, 1'b0, 1'b0, 2'd1);
      5'd1:    u = mk_uop(OP_MAC,  2'd2, 2'd2, 1'b0, 1'b0, 2'd1);
      5'd2:    u = mk_uop(OP_LDA,  2'd1, 2'd2, 1'b0, 1'b0, 2'd1);
      5'd3:    u = mk_uop(OP_MAC,  2'd2, 2'd1, 1'b1, 1'b0, 2'd1);
      5'd4:    u = mk_uop(OP_MOVD, 2'd0, 2'd0, 1'b0, 1'b0, 2'd1);
      5'd5:    u = mk_uop(OP_MAC,  2'd0, 2'd0, 1'b0, 1'b1, 2'd2);
      5'd6:    u = mk_uop(OP_LDA,  2'd1, 2'd0, 1'b0, 1'b0, 2'd1);
      5'd7:    u = mk_uop(OP_MAC,  2'd2, 2'd2, 1'b0, 1'b0, 2'd1);
      5'd8:    u = mk_uop(OP_LDA,  2'd1, 2'd2, 1'b0, 1'b0, 2'd1);
      5'd9:    u = mk_uop(OP_MAC,  2'd2, 2'd0, 1'b1, 1'b0, 2'd1);
      5'd10:   u = mk_uop(OP_MOVD, 2'd0, 2'd0, 1'b0, 1'b0, 2'd1);
      5'd11:   u = mk_uop(OP_MAC,  2'd0, 2'd1, 1'b1, 1'b1, 2'd2);
      5'd12:   u = mk_uop(OP_LDA,  2'd1, 2'd0, 1'b0, 1'b0, 2'd1);
      5'd13:   u = mk_uop(OP_MAC,  2'd2, 2'd1, 1'b0, 1'b0, 2'd1);
      5'd14:   u = mk_uop(OP_LDA,  2'd1, 2'd1, 1'b0, 1'b0, 2'd1);
      5'd15:   u = mk_uop(OP_MAC,  2'd2, 2'd0, 1'b1, 1'b0, 2'd1);
      5'd16:   u = mk_uop(OP_MOVD, 2'd0, 2'd0, 1'b0, 1'b0, 2'd1);
      5'd17:   u = mk_uop(OP_MAC,  2'd0, 2'd2, 1'b0, 1'b1, 2'd2);
      5'd18:   u = mk_uop(OP_STC,  2'd0, 2'd0, 1'b0, 1'b0, 2'd1);
      default: u = mk_uop(OP_MOVD, 2'd0, 2'd0, 1'b0, 1'b0, 2'd1);
    endcase
    return u;
  endfunction

  // Index among the three kept rows/columns -> real row/column
  function automatic logic [1:0] skip_map(logic [1:0] sel, logic [1:0] skip);
    return (sel < skip) ? sel : sel + 2'd1;
  endfunction

endpackage

[rtl/matrix4_inverse_cofactor.sv]
// Loads are accepted only while idle. After the last element the block computes
// all sixteen cofactors and the determinant, then gives either one singular
// result or the sixteen inverse elements in turn; no new load is taken until it
// is done. The cofactor pass is paced by the single 36x32 multiplier and the
// store read port, the output by the bit-serial divider. Results cannot be stalled.
// Reset (rst, sync) clears the element store's valid bits, so it reads as zero, and sets the threshold to 66.
module matrix4_inverse_cofactor
  import m4inv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  m4inv_in_t        load_item,
  input  logic             threshold_we,
  input  logic [THR_W-1:0] threshold_wdata,
  output logic             strobe,
  output m4inv_out_t       result
);

  state_t state;

  // Storage
  logic [ELEM_W-1:0]        mat_mem [16];
  logic [15:0]              mat_valid;
  logic [ELEM_W-1:0]        mat_q;
  logic                     vld_q;
  logic signed [C_W-1:0]    cof_mem [16];
  logic signed [C_W-1:0]    cof_q;

  logic [THR_W-1:0]         thr;

  // Sequencer
  logic [4:0]               step;
  logic [3:0]               cidx;
  logic                     detp;
  logic [1:0]               limb;
  logic [3:0]               k;
  logic [4:0]               bitc;

  // Datapath
  logic signed [OPA_W-1:0]  opa;
  logic signed [ELEM_W-1:0] e_reg;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [D_W-1:0]    acc_d;
  logic signed [ACC_W-1:0]  acc_m;
  logic [ACC_W-1:0]         dmag;
  logic                     dneg;
  logic [ELEM_W-1:0]        det_q;
  logic [C_W-1:0]           cmag;
  logic                     cneg;
  logic                     ovf;
  logic [ACC_W-1:0]         rem;
  logic [ELEM_W-1:0]        q;

  logic                     accept;
  uop_t                     cur;
  logic [1:0]               top;
  logic                     last_op;
  logic                     eff_neg;
  logic                     do_adv;
  state_t                   adv_state;
  logic [3:0]               mat_raddr;
  logic [3:0]               cof_raddr;
  logic [3:0]               mat_waddr;
  logic                     cof_we;
  logic signed [ELEM_W-1:0] elem;
  logic [OPND_W-1:0]        slice;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;
  logic [HI_W-1:0]          mag_hi;
  logic [ELEM_W-1:0]        det_sat;
  logic                     singular;
  logic [ACC_W:0]           rem_sh;
  logic [ACC_W:0]           rem_diff;
  logic                     rem_ge;
  logic                     qneg;
  logic [ELEM_W-1:0]        fin_val;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign mat_waddr = {load_item.row_index, load_item.col_index};

  // Current micro-operation
  always_comb begin
    if (detp) begin
      cur = mk_uop(step[0] ? OP_MAC : OP_LDC, 2'd0, 2'd0, 1'b0, 1'b1, 2'd3);
    end else begin
      cur = minor_uop(step);
    end
  end

  assign top     = cur.nlimbs - 2'd1;
  assign last_op = detp ? (step == DET_LAST) : (step == MINOR_LAST);
  // cofactor sign folded into the weighting terms
  assign eff_neg = cur.to_m ? (cur.neg ^ (!detp && (cidx[2] ^ cidx[0]))) : cur.neg;

  assign mat_raddr = detp ? {2'd3, step[2:1]}
                          : {skip_map(cur.rsel, cidx[3:2]), skip_map(cur.csel, cidx[1:0])};
  assign cof_raddr = (state == S_CFETCH) ? {k[1:0], k[3:2]} : {2'd3, step[2:1]};
  assign cof_we    = (state == S_OP) && (cur.kind == OP_STC);

  assign do_adv = ((state == S_OP) && (cur.kind == OP_MOVD || cur.kind == OP_STC)) ||
                  ((state == S_LAT) && (cur.kind != OP_MAC)) ||
                  ((state == S_ACC) && (limb == top));
  assign adv_state = (detp && last_op) ? S_DMAG : S_OP;

  // Unwritten entries read as zero
  assign elem = vld_q ? mat_q : '0;

  // Limb slice: lower limbs unsigned, top limb signed
  always_comb begin
    case (limb)
      2'd0:    slice = opa[35:0];
      2'd1:    slice = opa[67:32];
      default: slice = opa[99:64];
    endcase
    if (limb != top) begin
      slice[OPND_W-1:32] = '0;
    end
  end

  assign prod_c   = $signed(slice) * e_reg;
  assign prod_ext = ACC_W'(prod_q);

  always_comb begin
    case (limb)
      2'd0:    addend = prod_ext;
      2'd1:    addend = prod_ext <<< 32;
      default: addend = prod_ext <<< 64;
    endcase
  end

  // Determinant to Q16.16 and singular test
  assign mag_hi = dmag[ACC_W-1:DET_FRAC];
  always_comb begin
    if (!dneg) begin
      det_sat = (|mag_hi[HI_W-1:31]) ? SAT_POS : {1'b0, mag_hi[30:0]};
    end else if ((|mag_hi[HI_W-1:32]) || (mag_hi[31] && (|mag_hi[30:0]))) begin
      det_sat = SAT_NEG;
    end else begin
      det_sat = 32'd0 - mag_hi[31:0];
    end
  end
  assign singular = (dmag == '0) || (dmag < ACC_W'({thr, {DET_FRAC{1'b0}}}));

  // Restoring division step
  assign rem_sh   = {rem, 1'b0};
  assign rem_ge   = rem_sh >= {1'b0, dmag};
  assign rem_diff = rem_sh - {1'b0, dmag};

  // Saturated quotient
  assign qneg = cneg ^ dneg;
  always_comb begin
    if (ovf) begin
      fin_val = qneg ? SAT_NEG : SAT_POS;
    end else if (qneg) begin
      fin_val = (q[31] && (|q[30:0])) ? SAT_NEG : 32'd0 - q;
    end else begin
      fin_val = q[31] ? SAT_POS : q;
    end
  end

  // Element store
  always_ff @(posedge clk) begin
    if (accept) begin
      mat_mem[mat_waddr] <= load_item.element_value;
    end
    mat_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_valid <= '0;
      vld_q     <= 1'b0;
    end else begin
      if (accept) begin
        mat_valid[mat_waddr] <= 1'b1;
      end
      vld_q <= mat_valid[mat_raddr];
    end
  end

  // Cofactor store
  always_ff @(posedge clk) begin
    if (cof_we) begin
      cof_mem[cidx] <= acc_m[C_W-1:0];
    end
    cof_q <= cof_mem[cof_raddr];
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (threshold_we) begin
      thr <= threshold_wdata;
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      step   <= '0;
      cidx   <= '0;
      detp   <= 1'b0;
      limb   <= '0;
      k      <= '0;
      bitc   <= '0;
    end else begin
      strobe <= 1'b0;

      // program counters
      if (accept && load_item.last_element) begin
        step <= '0;
        cidx <= '0;
        detp <= 1'b0;
      end else if (do_adv) begin
        if (!last_op) begin
          step <= step + 5'd1;
        end else if (!detp) begin
          step <= '0;
          if (cidx == 4'd15) begin
            detp <= 1'b1;
          end else begin
            cidx <= cidx + 4'd1;
          end
        end
      end

      case (state)
        S_IDLE: begin
          if (accept && load_item.last_element) begin
            acc_d <= '0;
            acc_m <= '0;
            state <= S_OP;
          end
        end
        S_OP: begin
          case (cur.kind)
            OP_LDA, OP_LDC, OP_MAC: state <= S_LAT;
            OP_MOVD: begin
              opa   <= OPA_W'(acc_d);
              acc_d <= '0;
            end
            OP_STC: acc_m <= '0;
            default: state <= S_OP;
          endcase
          if (do_adv) begin
            state <= adv_state;
          end
        end
        S_LAT: begin
          case (cur.kind)
            OP_LDA: opa <= OPA_W'(elem);
            OP_LDC: opa <= OPA_W'(cof_q);
            default: begin
              e_reg <= elem;
              limb  <= '0;
            end
          endcase
          state <= do_adv ? adv_state : S_MUL;
        end
        S_MUL: begin
          prod_q <= prod_c;
          state  <= S_ACC;
        end
        S_ACC: begin
          if (cur.to_m) begin
            acc_m <= eff_neg ? acc_m - addend : acc_m + addend;
          end else begin
            acc_d <= eff_neg ? acc_d - addend[D_W-1:0] : acc_d + addend[D_W-1:0];
          end
          if (do_adv) begin
            state <= adv_state;
          end else begin
            limb  <= limb + 2'd1;
            state <= S_MUL;
          end
        end
        S_DMAG: begin
          dneg  <= acc_m[ACC_W-1];
          dmag  <= acc_m[ACC_W-1] ? ACC_W'(-acc_m) : ACC_W'(acc_m);
          state <= S_DCHK;
        end
        S_DCHK: begin
          det_q <= det_sat;
          k     <= '0;
          if (singular) begin
            result.inverse_value     <= '0;
            result.out_row           <= '0;
            result.out_col           <= '0;
            result.determinant_value <= det_sat;
            result.singular_flag     <= 1'b1;
            result.last_result       <= 1'b1;
            strobe                   <= 1'b1;
            state                    <= S_IDLE;
          end else begin
            state <= S_CFETCH;
          end
        end
        S_CFETCH: state <= S_CLOAD;
        S_CLOAD: begin
          cneg  <= cof_q[C_W-1];
          cmag  <= cof_q[C_W-1] ? C_W'(-cof_q) : C_W'(cof_q);
          state <= S_CCMP;
        end
        S_CCMP: begin
          ovf   <= ACC_W'(cmag) >= dmag;
          rem   <= ACC_W'(cmag);
          q     <= '0;
          bitc  <= '0;
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          rem  <= rem_ge ? rem_diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
          q    <= {q[30:0], rem_ge};
          bitc <= bitc + 5'd1;
          if (bitc == 5'd31) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          result.inverse_value     <= fin_val;
          result.out_row           <= k[3:2];
          result.out_col           <= k[1:0];
          result.determinant_value <= det_q;
          result.singular_flag     <= 1'b0;
          result.last_result       <= (k == 4'd15);
          strobe                   <= 1'b1;
          if (k == 4'd15) begin
            state <= S_IDLE;
          end else begin
            k     <= k + 4'd1;
            state <= S_CFETCH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_singular_alone: assert property (@(posedge clk) disable iff (rst)
    strobe && result.singular_flag |-> result.last_result && result.inverse_value == '0)
    else $error("singular result not alone or not zero");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    start && !busy && load_item.last_element |=> busy)
    else $error("last element did not start a run");

  a_run_ends_with_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> strobe && result.last_result)
    else $error("run ended without a final result");

  a_final_position: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_result && !result.singular_flag |->
      result.out_row == 2'd3 && result.out_col == 2'd3)
    else $error("final inverse element at wrong position");

endmodule

[sim/m4inv_checker.sv]
// Watches the load, threshold and result channels of the inverter, predicts
// every result with exact wide arithmetic and compares field by field.
module m4inv_checker
  import m4inv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  m4inv_in_t        load_item,
  input  logic             threshold_we,
  input  logic [THR_W-1:0] threshold_wdata,
  input  logic             strobe,
  input  m4inv_out_t       result,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [191:0] wide_t;

  logic [ELEM_W-1:0] elem_store [16];
  logic [THR_W-1:0]  det_floor;
  m4inv_out_t        inverse_q [$];

  assign pending = inverse_q.size();

  function automatic wide_t elem_at(int r, int c);
    wide_t v;
    v = $signed(elem_store[r * 4 + c]);
    return v;
  endfunction

  // 3x3 minor with one row and one column removed, 48 fraction bits
  function automatic wide_t minor_of(int skip_r, int skip_c);
    int    rr [3];
    int    cc [3];
    int    n;
    wide_t d01, d02, d12;
    n = 0;
    for (int i = 0; i < 4; i++) if (i != skip_r) begin rr[n] = i; n++; end
    n = 0;
    for (int i = 0; i < 4; i++) if (i != skip_c) begin cc[n] = i; n++; end
    d12 = elem_at(rr[1], cc[1]) * elem_at(rr[2], cc[2])
        - elem_at(rr[1], cc[2]) * elem_at(rr[2], cc[1]);
    d02 = elem_at(rr[1], cc[0]) * elem_at(rr[2], cc[2])
        - elem_at(rr[1], cc[2]) * elem_at(rr[2], cc[0]);
    d01 = elem_at(rr[1], cc[0]) * elem_at(rr[2], cc[1])
        - elem_at(rr[1], cc[1]) * elem_at(rr[2], cc[0]);
    return d12 * elem_at(rr[0], cc[0]) - d02 * elem_at(rr[0], cc[1])
         + d01 * elem_at(rr[0], cc[2]);
  endfunction

  // sign and magnitude to a saturated 32-bit pattern
  function automatic logic [31:0] clamp32(logic neg, logic [191:0] mag);
    if (neg) begin
      if (mag > 192'h8000_0000) return SAT_NEG;
      return -mag[31:0];
    end
    if (mag > 192'h7FFF_FFFF) return SAT_POS;
    return mag[31:0];
  endfunction

  // full inversion of the stored matrix, results pushed in output order
  task automatic predict_inverse();
    wide_t         cof [4][4];
    wide_t         det, num;
    logic [191:0]  dmag, nmag, floor_w;
    logic [31:0]   det_q;
    logic          dneg, nneg;
    m4inv_out_t    r;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        cof[i][j] = minor_of(i, j);
        if ((i + j) % 2 == 1) cof[i][j] = -cof[i][j];
      end
    det = '0;
    for (int j = 0; j < 4; j++) det = det + cof[3][j] * elem_at(3, j);
    dneg = det < 0;
    dmag = dneg ? -det : det;
    det_q = clamp32(dneg, dmag >> DET_FRAC);
    floor_w = {161'b0, det_floor} << DET_FRAC;
    if (det == 0 || dmag < floor_w) begin
      r = '0;
      r.determinant_value = det_q;
      r.singular_flag = 1'b1;
      r.last_result = 1'b1;
      inverse_q.push_back(r);
      return;
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        num = cof[j][i] <<< 32;
        nneg = num < 0;
        nmag = nneg ? -num : num;
        r = '0;
        r.inverse_value = clamp32(nneg != dneg, nmag / dmag);
        r.out_row = 2'(i);
        r.out_col = 2'(j);
        r.determinant_value = det_q;
        r.last_result = (i == 3 && j == 3);
        inverse_q.push_back(r);
      end
  endtask

  always @(posedge clk) begin
    m4inv_out_t e;
    if (rst) begin
      for (int k = 0; k < 16; k++) elem_store[k] = '0;
      det_floor <= THR_RESET;
      inverse_q.delete();
      errors <= 0;
    end else begin
      if (threshold_we) det_floor <= threshold_wdata;
      // load transfer
      if (start && !busy) begin
        elem_store[{load_item.row_index, load_item.col_index}] = load_item.element_value;
        if (load_item.last_element) predict_inverse();
      end
      // result transfer
      if (strobe) begin
        if (inverse_q.size() == 0) begin
          $error("result with nothing expected");
          errors <= errors + 1;
        end else begin
          e = inverse_q.pop_front();
          if (result !== e) errors <= errors + 1;
          if (result.inverse_value !== e.inverse_value)
            $error("inverse_value exp %0d act %0d", e.inverse_value, result.inverse_value);
          if (result.out_row !== e.out_row)
            $error("out_row exp %0d act %0d", e.out_row, result.out_row);
          if (result.out_col !== e.out_col)
            $error("out_col exp %0d act %0d", e.out_col, result.out_col);
          if (result.determinant_value !== e.determinant_value)
            $error("determinant_value exp %0d act %0d", e.determinant_value,
                   result.determinant_value);
          if (result.singular_flag !== e.singular_flag)
            $error("singular_flag exp %0d act %0d", e.singular_flag, result.singular_flag);
          if (result.last_result !== e.last_result)
            $error("last_result exp %0d act %0d", e.last_result, result.last_result);
        end
      end
    end
  end

endmodule

[sim/tb_top.sv]
// Stimulus and verdict for the 4x4 cofactor inverter.
module tb_top;
  import m4inv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  m4inv_in_t        load_item = '0;
  logic             threshold_we = 1'b0;
  logic [THR_W-1:0] threshold_wdata = '0;
  logic             strobe;
  m4inv_out_t       result;
  int               errors;
  int               pending;
  int               cycles = 0;
  int               loads_sent = 0;
  bit               allow_gaps = 1'b1;

  always #5 clk = ~clk;

  matrix4_inverse_cofactor DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .load_item(load_item),
    .threshold_we(threshold_we), .threshold_wdata(threshold_wdata),
    .strobe(strobe), .result(result)
  );

  m4inv_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .load_item(load_item),
    .threshold_we(threshold_we), .threshold_wdata(threshold_wdata),
    .strobe(strobe), .result(result), .errors(errors), .pending(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[matrix4_inverse_cofactor] ERROR");
      $finish;
    end
  end

  // one load transfer, with an optional idle burst ahead of it
  task automatic load_elem(logic [31:0] v, int r, int c, logic last);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    load_item.element_value <= v;
    load_item.row_index <= 2'(r);
    load_item.col_index <= 2'(c);
    load_item.last_element <= last;
    @(negedge clk);
    while (busy) @(negedge clk);
    loads_sent++;
  endtask

  // stop driving loads, wait for every result and let the block finish
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_floor(logic [THR_W-1:0] v);
    drain();
    threshold_we <= 1'b1;
    threshold_wdata <= v;
    @(negedge clk);
    threshold_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_elem();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1, 2, 3, 4: v = $urandom_range(0, 32'h0004_FFFF);
      5, 6, 7: v = {7'd0, 9'($urandom_range(0, 511)), 16'h0};
      8: v = 32'($urandom_range(0, 65535));
      default: v = $urandom();
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // a whole matrix in shuffled order, last marked on the final element
  task automatic load_matrix();
    int pos [16];
    int k, t;
    for (int i = 0; i < 16; i++) pos[i] = i;
    for (int i = 15; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = pos[i]; pos[i] = pos[k]; pos[k] = t;
    end
    for (int i = 0; i < 16; i++)
      load_elem(rand_elem(), pos[i] / 4, pos[i] % 4, i == 15);
  endtask

  initial begin
    // reset
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: all-zero store right after reset is singular
    load_elem(32'h0, 0, 0, 1'b1);
    // identity
    for (int i = 0; i < 16; i++)
      load_elem((i / 4 == i % 4) ? 32'h0001_0000 : 32'h0, i / 4, i % 4, i == 15);
    // zero determinant with a zero floor still counts as singular
    set_floor('0);
    load_elem(32'h0, 0, 0, 1'b1);
    // largest floor makes a unit determinant singular
    set_floor({THR_W{1'b1}});
    load_elem(32'h0001_0000, 0, 0, 1'b1);
    // tiny determinant equal to a floor of one LSB, so not singular
    set_floor(31'd1);
    load_elem(32'h0000_0001, 0, 0, 1'b1);
    // same with zero floor: inverse saturates positive, then negative
    set_floor('0);
    load_elem(32'h0000_0001, 0, 0, 1'b1);
    load_elem(32'hFFFF_FFFF, 0, 0, 1'b1);
    // extreme elements saturate the determinant
    load_elem(32'h7FFF_FFFF, 0, 0, 1'b0);
    load_elem(32'h8000_0000, 1, 1, 1'b1);

    // random phases with different floors
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_floor(THR_RESET);
        1: set_floor(31'($urandom_range(0, 32'h0001_0000)));
        2: set_floor({THR_W{1'b1}});
        3: set_floor('0);
        default: set_floor(31'($urandom_range(0, 1000)));
      endcase
      allow_gaps = (ph < 5);
      for (int n = 0; n < ((ph < 2) ? 2 : 1); n++) begin
        if ($urandom_range(0, 3) == 0) begin
          // noise: stray elements, some of them triggering early
          repeat ($urandom_range(1, 5))
            load_elem($urandom(), $urandom_range(0, 3), $urandom_range(0, 3),
                      $urandom_range(0, 3) == 0);
        end
        load_matrix();
      end
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("[matrix4_inverse_cofactor] OK");
    end else begin
      $display("[matrix4_inverse_cofactor] ERROR");
    end
    $finish;
  end

endmodule
